FILE: hw/rtl/baps_pkg.sv
// Shared types, constants and helpers for the Bezier anchor path sampler.
package baps_pkg;

  localparam int COORD_W = 24;
  localparam int STEP_W = 23;
  localparam int CP_W = 28;
  localparam int DIFF_W = CP_W + 1;
  localparam int T_W = 24;
  localparam int PROD_W = DIFF_W + T_W + 1;
  localparam int MAX_SEG_SAMPLES = 32;
  localparam int CNT_W = $clog2(MAX_SEG_SAMPLES + 1);
  localparam int DCNT_W = $clog2(T_W);
  localparam int DEC_STEPS = 9;
  localparam int STEPI_W = $clog2(DEC_STEPS);
  localparam logic [DEC_STEPS-1:0] LERP_MASK = 9'b100110111;
  localparam logic [STEP_W-1:0] STEP_RESET = 23'd25600;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    logic   first;
    logic   final_seg;
  } seg_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_DIV,
    B_MUL,
    B_ADD,
    B_EMIT
  } back_state_t;

  function automatic logic signed [COORD_W-1:0] sat_field(input logic signed [CP_W-1:0] v);
    logic signed [CP_W-1:0] r;
    logic signed [CP_W-1:0] hi;
    logic signed [CP_W-1:0] lo;
    r = (v + CP_W'(2)) >>> 2;
    hi = CP_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - CP_W'(1);
    if (r > hi) begin
      sat_field = hi[COORD_W-1:0];
    end else if (r < lo) begin
      sat_field = lo[COORD_W-1:0];
    end else begin
      sat_field = r[COORD_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/baps_queue.sv
// Two-entry segment command queue between front and back.
module baps_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  baps_pkg::seg_cmd_t push_cmd,
  input  logic               pop,
  output baps_pkg::seg_cmd_t head,
  output baps_pkg::q_status_t qst
);
  import baps_pkg::*;

  seg_cmd_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head = mem[rd_ptr];
  assign qst.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign qst.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/baps_front.sv
// Front end: takes anchors, keeps history, issues segment commands.
module baps_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  baps_pkg::point_t            anchor,
  input  logic                        is_last,
  input  logic [baps_pkg::STEP_W-1:0] step_size,
  input  baps_pkg::q_status_t         qst,
  output logic                        push,
  output baps_pkg::seg_cmd_t          push_cmd
);
  import baps_pkg::*;

  point_t   h0;
  point_t   h1;
  point_t   h2;
  logic [1:0] seen;
  logic     pend;
  seg_cmd_t pend_cmd;
  seg_cmd_t seg1;
  seg_cmd_t seg2;
  logic     accept;
  logic     active;
  logic     v1;
  logic     v2;

  assign in_ready = !pend && !qst.full;
  assign accept = in_valid && in_ready;
  assign active = (seen >= 2'd2) && (step_size != '0);
  assign v1 = active && (h0.x != h1.x);
  assign v2 = active && is_last && (anchor.x != h0.x);

  always_comb begin
    seg1.a = h2;
    seg1.b = h1;
    seg1.c = h0;
    seg1.first = (seen == 2'd2);
    seg1.final_seg = !v2;
    seg2.a = h1;
    seg2.b = h0;
    seg2.c = anchor;
    seg2.first = 1'b0;
    seg2.final_seg = 1'b1;
  end

  assign push = (accept && v1) || (pend && !qst.full);
  assign push_cmd = pend ? pend_cmd : seg1;

  always_ff @(posedge clk) begin
    if (accept && v2) begin
      pend_cmd <= seg2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h0 <= '0;
      h1 <= '0;
      h2 <= '0;
      seen <= '0;
      pend <= 1'b0;
    end else begin
      if (accept) begin
        if (is_last) begin
          h0 <= '0;
          h1 <= '0;
          h2 <= '0;
          seen <= '0;
        end else begin
          h2 <= h1;
          h1 <= h0;
          h0 <= anchor;
          if (seen != 2'd3) begin
            seen <= seen + 2'd1;
          end
        end
      end
      if (accept && v2) begin
        pend <= 1'b1;
      end else if (pend && !qst.full) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/baps_back.sv
// Back end: samples one segment with a shared divider and lerp unit.
module baps_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [baps_pkg::STEP_W-1:0]  step_size,
  input  baps_pkg::q_status_t          qst,
  input  baps_pkg::seg_cmd_t           head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2*baps_pkg::COORD_W-1:0] out_data,
  output logic                         out_last,
  output logic                         out_trunc
);
  import baps_pkg::*;

  back_state_t state;
  back_state_t state_next;
  seg_cmd_t    cmd;

  logic signed [CP_W-1:0] ctrl_x [4];
  logic signed [CP_W-1:0] ctrl_y [4];
  logic signed [CP_W-1:0] ln_x [4];
  logic signed [CP_W-1:0] ln_y [4];
  logic [COORD_W-1:0]     seg_len;
  logic                   trunc;
  logic [COORD_W-1:0]     offset;
  logic [CNT_W-1:0]       j;
  logic [COORD_W-1:0]     rem;
  logic [T_W-1:0]         quo;
  logic [DCNT_W-1:0]      dcnt;
  logic [STEPI_W-1:0]     stepi;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  logic signed [CP_W-1:0] ax, ay, bx, by, cx, cy;
  logic signed [CP_W-1:0] p1x, p1y;
  logic signed [COORD_W:0] dx;
  logic [COORD_W-1:0]     seg_len_w;
  logic [STEP_W+CNT_W-1:0] cap_w;
  logic [COORD_W:0]       rem2;
  logic                   ge;
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic signed [T_W:0]    tt;
  logic signed [PROD_W-1:0] bias_x, bias_y;
  logic signed [CP_W-1:0] lerp_x, lerp_y;
  logic [COORD_W:0]       off_sum;
  logic                   last_s;
  logic                   out_load;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (T_W - 1);

  always_comb begin
    ax = CP_W'(cmd.a.x);
    ay = CP_W'(cmd.a.y);
    bx = CP_W'(cmd.b.x);
    by = CP_W'(cmd.b.y);
    cx = CP_W'(cmd.c.x);
    cy = CP_W'(cmd.c.y);
    if (cmd.first) begin
      p1x = CP_W'(bx * 3 + cx);
      p1y = CP_W'(by + cy * 3);
    end else begin
      p1x = CP_W'(bx * 5 - ax);
      p1y = CP_W'(by * 5 - ay);
    end
    dx = (COORD_W+1)'(cmd.c.x) - (COORD_W+1)'(cmd.b.x);
    seg_len_w = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    cap_w = (STEP_W+CNT_W)'(step_size) * (STEP_W+CNT_W)'(MAX_SEG_SAMPLES);
  end

  assign rem2 = {rem, 1'b0};
  assign ge = rem2 >= {1'b0, seg_len};

  assign tt = $signed({1'b0, quo});
  assign diff_x = DIFF_W'(ln_x[1]) - DIFF_W'(ln_x[0]);
  assign diff_y = DIFF_W'(ln_y[1]) - DIFF_W'(ln_y[0]);
  assign bias_x = prod_x + ROUND_BIAS;
  assign bias_y = prod_y + ROUND_BIAS;
  assign lerp_x = ln_x[0] + CP_W'(bias_x >>> T_W);
  assign lerp_y = ln_y[0] + CP_W'(bias_y >>> T_W);

  assign off_sum = (COORD_W+1)'(offset) + (COORD_W+1)'(step_size);
  assign last_s = (j == CNT_W'(MAX_SEG_SAMPLES - 1)) || (off_sum >= {1'b0, seg_len});

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!qst.empty) state_next = B_SETUP;
      B_SETUP: state_next = B_DIV;
      B_DIV:   if (dcnt == DCNT_W'(T_W - 1)) state_next = B_MUL;
      B_MUL:   if (LERP_MASK[stepi]) state_next = B_ADD;
      B_ADD:   if (stepi == STEPI_W'(DEC_STEPS - 1)) state_next = B_EMIT;
               else state_next = B_MUL;
      B_EMIT:  if (out_load) state_next = last_s ? B_IDLE : B_DIV;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == B_IDLE) && !qst.empty;
    out_load = (state == B_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!qst.empty) begin
          cmd <= head;
        end
      end
      B_SETUP: begin
        ctrl_x[0] <= bx <<< 2;
        ctrl_y[0] <= by <<< 2;
        ctrl_x[1] <= p1x;
        ctrl_y[1] <= p1y;
        ctrl_x[2] <= CP_W'(cx * 3 + bx);
        ctrl_y[2] <= CP_W'(cy * 3 + by);
        ctrl_x[3] <= cx <<< 2;
        ctrl_y[3] <= cy <<< 2;
        seg_len <= seg_len_w;
        trunc <= (STEP_W+CNT_W)'(seg_len_w) > cap_w;
        offset <= '0;
        j <= '0;
        rem <= '0;
        quo <= '0;
        dcnt <= '0;
      end
      B_DIV: begin
        rem <= ge ? COORD_W'(rem2 - {1'b0, seg_len}) : rem2[COORD_W-1:0];
        quo <= {quo[T_W-2:0], ge};
        dcnt <= dcnt + DCNT_W'(1);
        if (dcnt == DCNT_W'(T_W - 1)) begin
          ln_x <= ctrl_x;
          ln_y <= ctrl_y;
          stepi <= '0;
        end
      end
      B_MUL: begin
        if (LERP_MASK[stepi]) begin
          prod_x <= PROD_W'(diff_x) * PROD_W'(tt);
          prod_y <= PROD_W'(diff_y) * PROD_W'(tt);
        end else begin
          ln_x[0] <= ln_x[1];
          ln_x[1] <= ln_x[2];
          ln_x[2] <= ln_x[3];
          ln_y[0] <= ln_y[1];
          ln_y[1] <= ln_y[2];
          ln_y[2] <= ln_y[3];
          stepi <= stepi + STEPI_W'(1);
        end
      end
      B_ADD: begin
        ln_x[0] <= ln_x[1];
        ln_x[1] <= ln_x[2];
        ln_x[2] <= ln_x[3];
        ln_x[3] <= lerp_x;
        ln_y[0] <= ln_y[1];
        ln_y[1] <= ln_y[2];
        ln_y[2] <= ln_y[3];
        ln_y[3] <= lerp_y;
        stepi <= stepi + STEPI_W'(1);
      end
      B_EMIT: begin
        if (out_load) begin
          out_data <= {sat_field(ln_y[3]), sat_field(ln_x[3])};
          out_last <= last_s && cmd.final_seg;
          out_trunc <= trunc;
          if (!last_s) begin
            offset <= off_sum[COORD_W-1:0];
            rem <= off_sum[COORD_W-1:0];
            quo <= '0;
            dcnt <= '0;
            j <= j + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/bezier_anchor_path_sampler.sv
// Top level of the Bezier anchor path sampler.
//
// Anchors enter on the s_axis stream (x, y signed Q15.8, tlast on the final
// anchor of a list). Curve samples leave on m_axis; tlast marks the final
// sample caused by one anchor, tuser flags samples of a segment that hit the
// 32-sample cap. The cfg channel writes step_size (always ready).
// The front end records history and queues segment commands (two entries);
// the back end samples one segment at a time. Per sample the back end runs a
// restoring divider for t and 9 de Casteljau steps (6 lerps, each a multiply
// state then an add state on one multiplier per axis, and 3 shifts), after
// a setup state per segment. An anchor closing a list can cause two segments,
// so up to 64 samples.
// A final output register lets the back end compute the next sample while the
// receiver stalls; it waits only to overwrite an untaken sample.
// Reset clears history, the queue and the output valid; step_size returns to
// 25600 (100.0).
module bezier_anchor_path_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // anchor_x, anchor_y
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // sample_x, sample_y
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // truncated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_data        // step_size
);
  import baps_pkg::*;

  logic [STEP_W-1:0] step_size;
  point_t            anchor;
  q_status_t         qst;
  logic              q_push;
  logic              q_pop;
  seg_cmd_t          push_cmd;
  seg_cmd_t          head;

  assign cfg_ready = 1'b1;
  assign anchor.x = s_axis_tdata[COORD_W-1:0];
  assign anchor.y = s_axis_tdata[2*COORD_W-1:COORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_size <= cfg_data;
    end
  end

  baps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .anchor    (anchor),
    .is_last   (s_axis_tlast),
    .step_size (step_size),
    .qst       (qst),
    .push      (q_push),
    .push_cmd  (push_cmd)
  );

  baps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .qst      (qst)
  );

  baps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .step_size (step_size),
    .qst       (qst),
    .head      (head),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_trunc (m_axis_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !qst.full)
    else $error("segment queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !qst.empty)
    else $error("segment queue underflow");

  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (step_size != '0))
    else $error("segment issued with zero step");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule
